// ===== rtl/lfu_pkg.sv =====
// shared constants, codes and controller/datapath types for the lfu slot table
package lfu_pkg;

    localparam int SLOT_N    = 32;
    localparam int IDX_W     = $clog2(SLOT_N);
    localparam int ID_BITS   = 8;
    localparam int CNT_W     = 16;
    localparam int STAMP_W   = 32;
    localparam int CFG_W     = 6;
    localparam int SLOT_W    = 5;
    localparam int ACTION_W  = 2;
    localparam int EVICT_W   = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_PLACE   = 2'd0,
        ACT_HIT     = 2'd1,
        ACT_REPLACE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic start;
        logic scan;
        logic write;
    } t_dp_cmd;

    typedef struct packed {
        logic id_zero;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/lfu_if.sv =====
// valid/ready channel interfaces for request words and result words
interface lfu_in_if
    import lfu_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ID_BITS-1:0] entry_id;

    modport source (output valid, output entry_id, input ready);
    modport sink   (input valid, input entry_id, output ready);
endinterface

interface lfu_out_if
    import lfu_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic [ACTION_W-1:0] action;
    logic [EVICT_W-1:0]  evicted_id;
    logic [CNT_W-1:0]    new_count;

    modport source (output valid, output slot, output action, output evicted_id,
                    output new_count, input ready);
    modport sink   (input valid, input slot, input action, input evicted_id,
                    input new_count, output ready);
endinterface

// ===== rtl/lfu_slot_replacement.sv =====
// top level: lfu slot replacement with oldest-stamp tie break
//
// i_in carries one id word per handshake; a word with id zero is taken and
// dropped with no result and no state change. o_out carries one result word
// (slot, action, evicted id, new count) for each nonzero id.
// i_cfg_we/i_cfg_wdata write slots_in_use; write it only while idle.
// an item is accepted in the idle state, then the slot table is scanned one
// slot a cycle from slot 0 until a hit, an empty slot, or the last active
// slot, then the write-back state loads the result register. the next item
// is taken only after write-back has returned to idle, so one item is done
// before the next is accepted; the single-ported scan of the slot table
// sets that pace.
// reset empties the table at once through per-slot valid bits, clears the
// stamp counter and sets slots_in_use to 32.
// if the receiver stalls, the result word holds in the output register and
// the following item scans, then waits in write-back until the word is taken.
module lfu_slot_replacement
    import lfu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    lfu_in_if.sink           i_in,
    lfu_out_if.source        o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    lfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lfu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_entry_id  (i_in.entry_id),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/lfu_ctrl.sv =====
// controller state machine: accept, slot scan, write-back
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                // a zero id is taken and dropped
                if (i_in_valid && !i_sts.id_zero) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.write = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lfu_dpath.sv =====
// datapath: slot table, scan index, victim tracking and result register
module lfu_dpath
    import lfu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic [ID_BITS-1:0] i_entry_id,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    lfu_out_if.source          o_out
);

    // slot table, entries read as zero until written
    logic [ID_BITS-1:0] r_tab_id    [SLOT_N];
    logic [CNT_W-1:0]   r_tab_cnt   [SLOT_N];
    logic [STAMP_W-1:0] r_tab_stamp [SLOT_N];
    logic [SLOT_N-1:0]  r_tab_vld;

    logic [CFG_W-1:0]   r_cfg_slots;
    logic [STAMP_W-1:0] r_ref_ctr;

    logic [ID_BITS-1:0] r_req_id;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_where;
    t_action            r_action;
    logic [CNT_W-1:0]   r_hit_cnt;
    logic [IDX_W-1:0]   r_vidx;
    logic [CNT_W-1:0]   r_vcnt;
    logic [STAMP_W-1:0] r_vstamp;
    logic [ID_BITS-1:0] r_vid;

    logic                r_out_valid;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [ACTION_W-1:0] r_out_action;
    logic [EVICT_W-1:0]  r_out_evict;
    logic [CNT_W-1:0]    r_out_cnt;

    logic [CFG_W-1:0]   n_eff;
    logic [CFG_W-1:0]   n_last;
    logic               scan_last;
    logic [ID_BITS-1:0] cur_id;
    logic [CNT_W-1:0]   cur_cnt;
    logic [STAMP_W-1:0] cur_stamp;
    logic               cur_hit;
    logic               cur_empty;
    logic               vic_take;
    logic [IDX_W-1:0]   wr_idx;
    logic [CNT_W-1:0]   n_cnt;

    always_comb begin
        if (r_cfg_slots == '0) begin
            n_eff = CFG_W'(1);
        end else if (r_cfg_slots > CFG_W'(SLOT_N)) begin
            n_eff = CFG_W'(SLOT_N);
        end else begin
            n_eff = r_cfg_slots;
        end
    end

    assign n_last    = n_eff - CFG_W'(1);
    assign scan_last = (r_idx == n_last[IDX_W-1:0]);

    assign cur_id    = r_tab_vld[r_idx] ? r_tab_id[r_idx]    : '0;
    assign cur_cnt   = r_tab_vld[r_idx] ? r_tab_cnt[r_idx]   : '0;
    assign cur_stamp = r_tab_vld[r_idx] ? r_tab_stamp[r_idx] : '0;
    assign cur_hit   = (cur_id == r_req_id);
    assign cur_empty = (cur_id == '0);

    // strict compare keeps the lowest index on a full tie
    assign vic_take = (r_idx == '0) || (cur_cnt < r_vcnt) ||
                      ((cur_cnt == r_vcnt) && (cur_stamp < r_vstamp));

    assign wr_idx = (r_action == ACT_REPLACE) ? r_vidx : r_where;

    always_comb begin
        if (r_action != ACT_HIT) begin
            n_cnt = CNT_W'(1);
        end else if (r_hit_cnt == COUNT_MAX) begin
            n_cnt = COUNT_MAX;
        end else begin
            n_cnt = r_hit_cnt + CNT_W'(1);
        end
    end

    assign o_sts.id_zero   = (i_entry_id == '0);
    assign o_sts.scan_done = cur_hit || cur_empty || scan_last;
    assign o_sts.out_free  = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_slots <= CFG_W'(SLOT_N);
        end else if (i_cfg_we) begin
            r_cfg_slots <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_ctr <= '0;
            r_tab_vld <= '0;
        end else if (i_cmd.write) begin
            r_ref_ctr <= r_ref_ctr + STAMP_W'(1);
            r_tab_vld[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_tab_cnt[wr_idx] <= n_cnt;
            if (r_action != ACT_HIT) begin
                r_tab_id[wr_idx]    <= r_req_id;
                r_tab_stamp[wr_idx] <= r_ref_ctr;
            end
        end
    end

    // scan: first hit or empty slot decides, else track the victim
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req_id <= i_entry_id;
            r_idx    <= '0;
        end else if (i_cmd.scan) begin
            if (cur_hit || cur_empty) begin
                r_where   <= r_idx;
                r_action  <= cur_hit ? ACT_HIT : ACT_PLACE;
                r_hit_cnt <= cur_cnt;
            end else begin
                if (vic_take) begin
                    r_vidx   <= r_idx;
                    r_vcnt   <= cur_cnt;
                    r_vstamp <= cur_stamp;
                    r_vid    <= cur_id;
                end
                if (scan_last) begin
                    r_action <= ACT_REPLACE;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.write) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_out_slot   <= SLOT_W'(wr_idx);
            r_out_action <= r_action;
            r_out_evict  <= (r_action == ACT_REPLACE) ? EVICT_W'(r_vid) : '0;
            r_out_cnt    <= n_cnt;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.slot       = r_out_slot;
    assign o_out.action     = r_out_action;
    assign o_out.evicted_id = r_out_evict;
    assign o_out.new_count  = r_out_cnt;

`ifndef SYNTHESIS
    a_write_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> (!r_out_valid || o_out.ready))
        else $error("write-back with result register still held");

    a_write_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |=> (r_out_valid && r_tab_vld[$past(wr_idx)]))
        else $error("write-back did not fill result and slot");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> ({1'b0, r_idx} < n_eff))
        else $error("scan index beyond active slots");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> (n_cnt != '0))
        else $error("written count is zero");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench for lfu_slot_replacement: directed script followed by random phases
module testbench;
    import lfu_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_REFS   = 690;
    localparam int SCRIPT_LEN    = 30;
    localparam int FIFO_DEPTH    = 16;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        t_action            action;
        logic [EVICT_W-1:0] evicted_id;
        logic [CNT_W-1:0]   new_count;
    } t_lfu_result;

    typedef enum logic [0:0] {
        ROW_REF,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        logic [7:0]   value;
        logic         typed;
        t_lfu_result  want;
    } t_script_row;

    localparam t_lfu_result NO_RESULT = '{5'd0, ACT_PLACE, 8'd0, 16'd0};

    // typed rows carry a result readable by hand; the rest use the predictor
    t_script_row script [SCRIPT_LEN] = '{
        '{ROW_REF, 8'd1,   1'b1, '{5'd0, ACT_PLACE,   8'd0,   16'd1}},
        '{ROW_REF, 8'd255, 1'b1, '{5'd1, ACT_PLACE,   8'd0,   16'd1}},
        '{ROW_REF, 8'd1,   1'b1, '{5'd0, ACT_HIT,     8'd0,   16'd2}},
        '{ROW_REF, 8'd0,   1'b1, NO_RESULT},
        '{ROW_REF, 8'd128, 1'b1, '{5'd2, ACT_PLACE,   8'd0,   16'd1}},
        '{ROW_CFG, 8'd2,   1'b0, NO_RESULT},
        '{ROW_REF, 8'd128, 1'b1, '{5'd1, ACT_REPLACE, 8'd255, 16'd1}},
        '{ROW_REF, 8'd77,  1'b1, '{5'd1, ACT_REPLACE, 8'd128, 16'd1}},
        '{ROW_CFG, 8'd0,   1'b0, NO_RESULT},
        '{ROW_REF, 8'd9,   1'b1, '{5'd0, ACT_REPLACE, 8'd1,   16'd1}},
        '{ROW_REF, 8'd9,   1'b1, '{5'd0, ACT_HIT,     8'd0,   16'd2}},
        '{ROW_REF, 8'd0,   1'b1, NO_RESULT},
        '{ROW_CFG, 8'd63,  1'b0, NO_RESULT},
        '{ROW_REF, 8'd128, 1'b1, '{5'd2, ACT_HIT,     8'd0,   16'd2}},
        '{ROW_REF, 8'd200, 1'b0, NO_RESULT},
        '{ROW_CFG, 8'd3,   1'b0, NO_RESULT},
        '{ROW_REF, 8'd50,  1'b0, NO_RESULT},
        '{ROW_REF, 8'd51,  1'b0, NO_RESULT},
        '{ROW_REF, 8'd77,  1'b0, NO_RESULT},
        '{ROW_REF, 8'h7F,  1'b0, NO_RESULT},
        '{ROW_REF, 8'h80,  1'b0, NO_RESULT},
        '{ROW_CFG, 8'd33,  1'b0, NO_RESULT},
        '{ROW_REF, 8'd200, 1'b0, NO_RESULT},
        '{ROW_REF, 8'hAA,  1'b0, NO_RESULT},
        '{ROW_REF, 8'h55,  1'b0, NO_RESULT},
        '{ROW_CFG, 8'd1,   1'b0, NO_RESULT},
        '{ROW_REF, 8'd255, 1'b0, NO_RESULT},
        '{ROW_REF, 8'd1,   1'b0, NO_RESULT},
        '{ROW_CFG, 8'd32,  1'b0, NO_RESULT},
        '{ROW_REF, 8'd254, 1'b0, NO_RESULT}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    lfu_in_if  req_if ();
    lfu_out_if res_if ();

    lfu_slot_replacement uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (req_if),
        .o_out       (res_if)
    );

    // shadow copy of the slot table
    logic [ID_BITS-1:0] tbl_id    [SLOT_N];
    logic [CNT_W-1:0]   tbl_count [SLOT_N];
    logic [STAMP_W-1:0] tbl_stamp [SLOT_N];
    logic [STAMP_W-1:0] ref_seq;
    logic [CFG_W-1:0]   slot_limit;

    // expected words in order; sender advances put_count, checker take_count
    t_lfu_result want_fifo [FIFO_DEPTH];
    int  put_count;
    int  take_count;

    int  errors;
    int  cycle_count;
    int  stall_left;
    bit  rx_steady;
    int  refs_sent;
    int  zero_refs;
    int  cfg_writes;
    int  action_seen [3];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int active_slots();
        if (slot_limit == '0) return 1;
        if (slot_limit > SLOT_N) return SLOT_N;
        return int'(slot_limit);
    endfunction

    // lookup, then hit / place / evict least-used oldest entry
    function automatic t_lfu_result apply_ref(input logic [ID_BITS-1:0] id);
        int          n;
        int          k;
        int          pick;
        t_lfu_result r;
        n = active_slots();
        pick = 0;
        r.action = ACT_REPLACE;
        r.evicted_id = '0;
        for (k = 0; k < n; k++) begin
            if (tbl_id[k] == id) begin
                r.action = ACT_HIT;
                pick = k;
                break;
            end
            if (tbl_id[k] == '0) begin
                r.action = ACT_PLACE;
                pick = k;
                break;
            end
        end
        if (r.action == ACT_HIT) begin
            if (tbl_count[pick] != COUNT_MAX) tbl_count[pick] = tbl_count[pick] + 1'b1;
        end else begin
            if (r.action == ACT_REPLACE) begin
                pick = 0;
                for (k = 1; k < n; k++) begin
                    if (tbl_count[k] < tbl_count[pick] ||
                        (tbl_count[k] == tbl_count[pick] && tbl_stamp[k] < tbl_stamp[pick]))
                        pick = k;
                end
                r.evicted_id = tbl_id[pick];
            end
            tbl_id[pick]    = id;
            tbl_count[pick] = 1;
            tbl_stamp[pick] = ref_seq;
        end
        ref_seq = ref_seq + 1'b1;
        r.slot = SLOT_W'(pick);
        r.new_count = tbl_count[pick];
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    task automatic send_ref(input logic [ID_BITS-1:0] id, input int gap, input bit typed,
                            input t_lfu_result want);
        t_lfu_result got;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.entry_id <= id;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        if (id != '0) begin
            got = apply_ref(id);
            want_fifo[put_count % FIFO_DEPTH] = typed ? want : got;
            put_count++;
            action_seen[got.action]++;
        end else begin
            zero_refs++;
        end
    endtask

    task automatic drain(input int settle);
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (put_count != take_count) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_slots(input logic [CFG_W-1:0] value);
        drain(SETTLE_CYCLES);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        slot_limit = value;
        cfg_writes++;
    endtask

    task automatic check_result();
        t_lfu_result got;
        t_lfu_result exp;
        got = '{res_if.slot, t_action'(res_if.action), res_if.evicted_id, res_if.new_count};
        if (put_count == take_count) begin
            if (errors < 10)
                $display("unexpected result word: slot %0d action %0d evicted %0d count %0d",
                         got.slot, got.action, got.evicted_id, got.new_count);
            errors++;
        end else begin
            exp = want_fifo[take_count % FIFO_DEPTH];
            take_count++;
            if (got !== exp) begin
                if (errors < 10) begin
                    $write("mismatch at cycle %0d: slot %0d/%0d action %0d/%0d ",
                           cycle_count, exp.slot, got.slot, exp.action, got.action);
                    $display("evicted %0d/%0d count %0d/%0d (expected/actual)",
                             exp.evicted_id, got.evicted_id, exp.new_count, got.new_count);
                end
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, put_count - take_count);
            $display("testbench: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) check_result();
            if (rx_steady) begin
                res_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = idle_len();
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int          idx;
        int          n;
        int          pool;
        int          base;
        int          phase;
        int          items;
        int          r;
        bit          quiet;
        logic [7:0]  id;
        logic [CFG_W-1:0] setting;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        req_if.valid    = 1'b0;
        req_if.entry_id = '0;
        foreach (tbl_id[k]) begin
            tbl_id[k]    = '0;
            tbl_count[k] = '0;
            tbl_stamp[k] = '0;
        end
        ref_seq    = '0;
        slot_limit = CFG_W'(SLOT_N);
        rx_steady  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (idx = 0; idx < SCRIPT_LEN; idx++) begin
            if (script[idx].kind == ROW_CFG)
                write_slots(CFG_W'(script[idx].value));
            else
                send_ref(script[idx].value, idle_len(), script[idx].typed, script[idx].want);
        end

        phase = 0;
        refs_sent = 0;
        while (refs_sent < RANDOM_REFS) begin
            case (phase)
                0: setting = 6'd1;
                1: setting = 6'd32;
                2: setting = 6'd0;
                3: setting = 6'd63;
                4: setting = 6'd2;
                5: setting = 6'd33;
                default: setting = CFG_W'($urandom_range(0, 63));
            endcase
            write_slots(setting);
            quiet = ($urandom_range(0, 3) == 0);
            rx_steady = quiet;
            n = active_slots();
            pool = $urandom_range(1, n + n / 2 + 2);
            base = $urandom_range(1, 256 - pool);
            items = $urandom_range(40, 110);
            for (idx = 0; idx < items && refs_sent < RANDOM_REFS; idx++) begin
                if ($urandom_range(0, 29) == 0) drain(1);
                r = $urandom_range(0, 99);
                if (r < 4)
                    id = 8'd0;
                else if (r < 12)
                    id = 8'($urandom_range(0, 255));
                else
                    id = 8'(base + $urandom_range(0, pool - 1));
                send_ref(id, quiet ? 0 : idle_len(), 1'b0, NO_RESULT);
                if (id != 8'd0) refs_sent++;
            end
            rx_steady = 1'b0;
            phase++;
        end

        drain(SETTLE_CYCLES);
        $display("covered %0d references (%0d zero ids dropped) over %0d slot-count writes",
                 action_seen[0] + action_seen[1] + action_seen[2], zero_refs, cfg_writes);
        $display("placed %0d, hit %0d, replaced %0d; %0d bad",
                 action_seen[ACT_PLACE], action_seen[ACT_HIT], action_seen[ACT_REPLACE],
                 errors);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lfu_pkg.sv
rtl/lfu_if.sv
rtl/lfu_ctrl.sv
rtl/lfu_dpath.sv
rtl/lfu_slot_replacement.sv
tb/testbench.sv
